// File: hw/rtl/lzwc_pkg.sv
// lzwc_pkg: constants and transfer types for the lzw compressor
// no dependencies; used by lzw_compressor
package lzwc_pkg;

    localparam int HASH_SIZE     = 5003;
    localparam int CODE_BITS_MAX = 12;
    localparam int START_BITS    = 9;
    localparam int FIRST_CODE    = 257;
    localparam int CLEAR_CODE    = 256;

    localparam int SLOT_W     = $clog2(HASH_SIZE);
    localparam int CODE_W     = CODE_BITS_MAX;
    localparam int NFC_W      = CODE_BITS_MAX + 1;
    localparam int KEY_W      = CODE_BITS_MAX + 9;
    localparam int CW_W       = $clog2(CODE_BITS_MAX + 2);
    localparam int PACK_DEPTH = CODE_BITS_MAX;
    localparam int PIDX_W     = $clog2(PACK_DEPTH + 1);
    localparam int BO_W       = $clog2(CODE_BITS_MAX * 8 + 1);
    localparam int CFG_DATA_W = 20;

    localparam logic [7:0]  MAGIC_0      = 8'h1F;
    localparam logic [7:0]  MAGIC_1      = 8'h9D;
    localparam logic [31:0] RATIO_BIG    = 32'h007F_FFFF;
    localparam logic [31:0] RATIO_INF    = 32'h7FFF_FFFF;
    localparam logic [31:0] CHECK_RESET  = 32'd10000;

    function automatic int hash_shift_f();
        int f;
        int s;
        f = HASH_SIZE;
        s = 0;
        while (f < 65536) begin
            f = f * 2;
            s = s + 1;
        end
        return (s > 8) ? 0 : 8 - s;
    endfunction

    localparam int HASH_SHIFT = hash_shift_f();

    typedef enum logic [1:0] {
        CFG_MAX_CODE_BITS  = 2'd0,
        CFG_BLOCK_MODE     = 2'd1,
        CFG_CHECK_INTERVAL = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       stream_done;
    } out_item_t;

endpackage

// File: hw/rtl/lzw_compressor.sv
// lzw_compressor: compress-format lzw encoder with hash table memory and ratio check
// depends on lzwc_pkg (constants, transfer structs)
// steps: a byte is looked up by hash probes in the table; a miss adds code packing
//   and a flush of the packed bytes, and a ratio check adds a serial division
// flow: a new byte is taken only in S_IDLE, once the previous one is through
// reset: a clearing pass sweeps the hash table; it reruns at each stream
//   start and each CLEAR, and in_ready stays low while it runs
module lzw_compressor (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  lzwc_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output lzwc_pkg::out_item_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [lzwc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int SW = lzwc_pkg::SLOT_W;
    localparam logic [SW-1:0] HSIZE = SW'(lzwc_pkg::HASH_SIZE);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_HDR   = 14'b00000000000010,
        S_LOOK  = 14'b00000000000100,
        S_PACK  = 14'b00000000001000,
        S_POST  = 14'b00000000010000,
        S_WID   = 14'b00000000100000,
        S_WID2  = 14'b00000001000000,
        S_FLUSH = 14'b00000010000000,
        S_MISS  = 14'b00000100000000,
        S_DIV   = 14'b00001000000000,
        S_RCMP  = 14'b00010000000000,
        S_EOS   = 14'b00100000000000,
        S_TAIL  = 14'b01000000000000,
        S_DONE  = 14'b10000000000000
    } state_t;

    typedef enum logic [1:0] {
        R_MISS  = 2'd0,
        R_RATIO = 2'd1,
        R_EOS   = 2'd2
    } ret_t;

    typedef enum logic [1:0] {
        F_WID  = 2'd0,
        F_WID2 = 2'd1,
        F_DONE = 2'd2
    } fret_t;

    typedef struct packed {
        logic                          valid;
        logic [lzwc_pkg::KEY_W-1:0]    key;
        logic [lzwc_pkg::CODE_W-1:0]   code;
    } hent_t;

    function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // hash table memory
    hent_t mem [lzwc_pkg::HASH_SIZE];
    hent_t mem_rd_data_reg;
    logic mem_re;
    logic mem_we;
    logic [SW-1:0] mem_raddr;
    logic [SW-1:0] mem_waddr;
    hent_t mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rd_data_reg <= mem[mem_raddr];
        end
    end

    state_t state_reg, state_next;
    ret_t ret_reg, ret_next;
    fret_t fret_reg, fret_next;
    logic [7:0] c_reg, c_next;
    logic eos_reg, eos_next;
    logic [3:0] max_bits_reg, max_bits_next;
    logic block_mode_reg, block_mode_next;
    logic [lzwc_pkg::CFG_DATA_W-1:0] interval_reg, interval_next;
    logic [3:0] stream_bits_reg, stream_bits_next;
    logic stream_block_reg, stream_block_next;
    logic [lzwc_pkg::NFC_W-1:0] top_code_reg, top_code_next;
    logic [7:0] pack_reg [lzwc_pkg::PACK_DEPTH];
    logic [7:0] pack_next [lzwc_pkg::PACK_DEPTH];
    logic [lzwc_pkg::BO_W-1:0] bo_reg, bo_next;
    logic [lzwc_pkg::CW_W-1:0] cw_reg, cw_next;
    logic [lzwc_pkg::NFC_W-1:0] wlc_reg, wlc_next;
    logic [lzwc_pkg::NFC_W-1:0] nfc_reg, nfc_next;
    logic [lzwc_pkg::CODE_W-1:0] prefix_reg, prefix_next;
    logic started_reg, started_next;
    logic cp_reg, cp_next;
    logic [31:0] bytes_in_reg, bytes_in_next;
    logic [31:0] emitted_reg, emitted_next;
    logic [31:0] best_reg, best_next;
    logic [31:0] next_check_reg, next_check_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [SW-1:0] disp_reg, disp_next;
    logic [SW-1:0] tries_reg, tries_next;
    logic empty_reg, empty_next;
    logic clr_busy_reg, clr_busy_next;
    logic [SW-1:0] clr_addr_reg, clr_addr_next;
    logic [15:0] ev_reg, ev_next;
    logic [4:0] erem_reg, erem_next;
    logic [PIDX_BITS-1:0] pidx_reg, pidx_next;
    logic [2:0] eoff_reg, eoff_next;
    logic efirst_reg, efirst_next;
    logic [PIDX_BITS-1:0] fcnt_reg, fcnt_next;
    logic [PIDX_BITS-1:0] flen_reg, flen_next;
    logic [1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [31:0] div_q_reg, div_q_next;
    logic [32:0] div_r_reg, div_r_next;
    logic [31:0] div_d_reg, div_d_next;
    logic [4:0] div_cnt_reg, div_cnt_next;
    logic hold_valid_reg, hold_valid_next;
    logic [7:0] hold_byte_reg, hold_byte_next;
    logic out_valid_reg, out_valid_next;
    lzwc_pkg::out_item_t out_data_reg, out_data_next;

    localparam int PIDX_BITS = lzwc_pkg::PIDX_W;

    logic out_free;
    logic can_put;
    logic put_en;
    logic [7:0] put_byte;
    logic emit_go;
    logic [lzwc_pkg::NFC_W-1:0] emit_code;
    ret_t emit_ret;
    logic flush_go;
    logic [PIDX_BITS-1:0] flush_len;
    fret_t flush_ret;
    logic clr_start;
    logic miss_wr;
    logic [lzwc_pkg::KEY_W-1:0] cur_key;
    logic [SW:0] hash_x;
    logic [SW-1:0] slot0;
    logic [SW:0] nslot_wide;
    logic [3:0] step;
    logic [7:0] pack_rd;
    logic [PIDX_BITS-1:0] pack_rd_idx;
    logic [7:0] pbyte;
    logic [32:0] div_rs;
    logic [3:0] w_clamp;
    logic [lzwc_pkg::CW_W-1:0] cw_inc;
    logic [31:0] dividend;
    logic [31:0] divisor;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE) && !clr_busy_reg && !hold_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign can_put   = !hold_valid_reg || out_free;

    assign cur_key = (lzwc_pkg::KEY_W'(c_reg) << stream_bits_reg)
                     + lzwc_pkg::KEY_W'(prefix_reg);
    assign hash_x = (SW+1)'((SW+1)'(in_data.data_byte) << lzwc_pkg::HASH_SHIFT)
                    ^ (SW+1)'(prefix_reg);
    assign slot0 = (hash_x >= (SW+1)'(lzwc_pkg::HASH_SIZE))
                   ? SW'(hash_x - (SW+1)'(lzwc_pkg::HASH_SIZE)) : SW'(hash_x);
    assign nslot_wide = (slot_reg >= disp_reg)
                        ? (SW+1)'(slot_reg - disp_reg)
                        : (SW+1)'(slot_reg) + (SW+1)'(HSIZE) - (SW+1)'(disp_reg);
    assign pack_rd_idx = (state_reg == S_FLUSH) ? fcnt_reg : pidx_reg;
    assign pack_rd = (pack_rd_idx < PIDX_BITS'(lzwc_pkg::PACK_DEPTH))
                     ? pack_reg[pack_rd_idx] : 8'h00;
    assign step = efirst_reg ? (4'd8 - {1'b0, eoff_reg}) : 4'd8;
    assign pbyte = efirst_reg
                   ? ((pack_rd & ((8'd1 << eoff_reg) - 8'd1)) | 8'(ev_reg[7:0] << eoff_reg))
                   : ev_reg[7:0];
    assign div_rs = {div_r_reg[31:0], div_q_reg[31]};
    assign w_clamp = (max_bits_reg < 4'(lzwc_pkg::START_BITS)) ? 4'(lzwc_pkg::START_BITS)
                   : (max_bits_reg > 4'(lzwc_pkg::CODE_BITS_MAX))
                     ? 4'(lzwc_pkg::CODE_BITS_MAX) : max_bits_reg;
    assign cw_inc = cw_reg + 1'b1;
    assign dividend = (bytes_in_reg > lzwc_pkg::RATIO_BIG) ? bytes_in_reg
                                                           : {bytes_in_reg[23:0], 8'h00};
    assign divisor  = (bytes_in_reg > lzwc_pkg::RATIO_BIG) ? {8'h00, emitted_reg[31:8]}
                                                           : emitted_reg;
    assign miss_wr = (state_reg == S_MISS) && (nfc_reg < top_code_reg) && empty_reg;

    always_comb
    begin
        state_next = state_reg;
        ret_next = ret_reg;
        fret_next = fret_reg;
        c_next = c_reg;
        eos_next = eos_reg;
        max_bits_next = max_bits_reg;
        block_mode_next = block_mode_reg;
        interval_next = interval_reg;
        stream_bits_next = stream_bits_reg;
        stream_block_next = stream_block_reg;
        top_code_next = top_code_reg;
        pack_next = pack_reg;
        bo_next = bo_reg;
        cw_next = cw_reg;
        wlc_next = wlc_reg;
        nfc_next = nfc_reg;
        prefix_next = prefix_reg;
        started_next = started_reg;
        cp_next = cp_reg;
        bytes_in_next = bytes_in_reg;
        emitted_next = emitted_reg;
        best_next = best_reg;
        next_check_next = next_check_reg;
        slot_next = slot_reg;
        disp_next = disp_reg;
        tries_next = tries_reg;
        empty_next = empty_reg;
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        ev_next = ev_reg;
        erem_next = erem_reg;
        pidx_next = pidx_reg;
        eoff_next = eoff_reg;
        efirst_next = efirst_reg;
        fcnt_next = fcnt_reg;
        flen_next = flen_reg;
        hdr_cnt_next = hdr_cnt_reg;
        div_q_next = div_q_reg;
        div_r_next = div_r_reg;
        div_d_next = div_d_reg;
        div_cnt_next = div_cnt_reg;
        hold_valid_next = hold_valid_reg;
        hold_byte_next = hold_byte_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next = out_data_reg;
        put_en = 1'b0;
        put_byte = 8'h00;
        emit_go = 1'b0;
        emit_code = '0;
        emit_ret = R_EOS;
        flush_go = 1'b0;
        flush_len = '0;
        flush_ret = F_DONE;
        clr_start = 1'b0;
        mem_re = 1'b0;
        mem_raddr = slot0;
        mem_we = 1'b0;
        mem_waddr = slot_reg;
        mem_wdata = '0;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lzwc_pkg::CFG_MAX_CODE_BITS:  max_bits_next = cfg_data[3:0];
                lzwc_pkg::CFG_BLOCK_MODE:     block_mode_next = cfg_data[0];
                lzwc_pkg::CFG_CHECK_INTERVAL: interval_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    c_next = in_data.data_byte;
                    eos_next = in_data.end_of_stream;
                    if (!started_reg)
                    begin
                        stream_bits_next = w_clamp;
                        stream_block_next = block_mode_reg;
                        top_code_next = lzwc_pkg::NFC_W'(1) << w_clamp;
                        bo_next = '0;
                        emitted_next = 32'd3;
                        cp_next = 1'b0;
                        best_next = '0;
                        bytes_in_next = 32'd1;
                        next_check_next = 32'(interval_reg);
                        cw_next = lzwc_pkg::CW_W'(lzwc_pkg::START_BITS);
                        wlc_next = (lzwc_pkg::NFC_W'(1) << lzwc_pkg::START_BITS) - 1'b1;
                        nfc_next = block_mode_reg ? lzwc_pkg::NFC_W'(lzwc_pkg::FIRST_CODE)
                                                  : lzwc_pkg::NFC_W'(lzwc_pkg::CLEAR_CODE);
                        prefix_next = lzwc_pkg::CODE_W'(in_data.data_byte);
                        started_next = 1'b1;
                        clr_start = 1'b1;
                        hdr_cnt_next = '0;
                        state_next = S_HDR;
                    end
                    else
                    begin
                        bytes_in_next = sat_add(bytes_in_reg, 32'd1);
                        mem_re = 1'b1;
                        mem_raddr = slot0;
                        slot_next = slot0;
                        disp_next = (slot0 == '0) ? SW'(1) : HSIZE - slot0;
                        tries_next = '0;
                        state_next = S_LOOK;
                    end
                end
            end
            S_HDR:
            begin
                if (can_put)
                begin
                    put_en = 1'b1;
                    unique case (hdr_cnt_reg)
                        2'd0: put_byte = lzwc_pkg::MAGIC_0;
                        2'd1: put_byte = lzwc_pkg::MAGIC_1;
                        default: put_byte = {stream_block_reg, 3'b000, stream_bits_reg};
                    endcase
                    hdr_cnt_next = hdr_cnt_reg + 2'd1;
                    if (hdr_cnt_reg == 2'd2)
                    begin
                        state_next = S_EOS;
                    end
                end
            end
            S_LOOK:
            begin
                if (mem_rd_data_reg.valid && mem_rd_data_reg.key == cur_key)
                begin
                    prefix_next = mem_rd_data_reg.code;
                    state_next = S_EOS;
                end
                else if (!mem_rd_data_reg.valid || tries_reg == HSIZE)
                begin
                    empty_next = !mem_rd_data_reg.valid;
                    emit_go = 1'b1;
                    emit_code = lzwc_pkg::NFC_W'(prefix_reg);
                    emit_ret = R_MISS;
                end
                else
                begin
                    mem_re = 1'b1;
                    mem_raddr = SW'(nslot_wide);
                    slot_next = SW'(nslot_wide);
                    tries_next = tries_reg + 1'b1;
                end
            end
            S_PACK:
            begin
                if (pidx_reg < PIDX_BITS'(lzwc_pkg::PACK_DEPTH))
                begin
                    pack_next[pidx_reg] = pbyte;
                end
                ev_next = ev_reg >> step;
                pidx_next = pidx_reg + 1'b1;
                efirst_next = 1'b0;
                if (erem_reg <= {1'b0, step})
                begin
                    bo_next = bo_reg + lzwc_pkg::BO_W'(cw_reg);
                    state_next = S_POST;
                end
                else
                begin
                    erem_next = erem_reg - {1'b0, step};
                end
            end
            S_POST:
            begin
                if (bo_reg == lzwc_pkg::BO_W'({cw_reg, 3'b000}))
                begin
                    bo_next = '0;
                    flush_go = 1'b1;
                    flush_len = PIDX_BITS'(cw_reg);
                    flush_ret = F_WID;
                end
                else
                begin
                    state_next = S_WID;
                end
            end
            S_WID:
            begin
                if (nfc_reg > wlc_reg || cp_reg)
                begin
                    if (bo_reg != '0)
                    begin
                        flush_go = 1'b1;
                        flush_len = PIDX_BITS'(cw_reg);
                        flush_ret = F_WID2;
                    end
                    else
                    begin
                        state_next = S_WID2;
                    end
                end
                else
                begin
                    unique case (ret_reg)
                        R_MISS:  state_next = S_MISS;
                        R_RATIO: state_next = S_EOS;
                        default: state_next = S_TAIL;
                    endcase
                end
            end
            S_WID2:
            begin
                bo_next = '0;
                if (cp_reg)
                begin
                    cw_next = lzwc_pkg::CW_W'(lzwc_pkg::START_BITS);
                    wlc_next = (lzwc_pkg::NFC_W'(1) << lzwc_pkg::START_BITS) - 1'b1;
                    cp_next = 1'b0;
                end
                else
                begin
                    cw_next = cw_inc;
                    wlc_next = (4'(cw_inc) == stream_bits_reg) ? top_code_reg
                             : (lzwc_pkg::NFC_W'(1) << cw_inc) - 1'b1;
                end
                unique case (ret_reg)
                    R_MISS:  state_next = S_MISS;
                    R_RATIO: state_next = S_EOS;
                    default: state_next = S_TAIL;
                endcase
            end
            S_FLUSH:
            begin
                if (can_put)
                begin
                    put_en = 1'b1;
                    put_byte = pack_rd;
                    fcnt_next = fcnt_reg + 1'b1;
                    if (fcnt_reg + 1'b1 == flen_reg)
                    begin
                        unique case (fret_reg)
                            F_WID:   state_next = S_WID;
                            F_WID2:  state_next = S_WID2;
                            default: state_next = S_DONE;
                        endcase
                    end
                end
            end
            S_MISS:
            begin
                prefix_next = lzwc_pkg::CODE_W'(c_reg);
                if (nfc_reg < top_code_reg)
                begin
                    if (empty_reg)
                    begin
                        mem_we = 1'b1;
                        mem_waddr = slot_reg;
                        mem_wdata = '{valid: 1'b1, key: cur_key,
                                      code: lzwc_pkg::CODE_W'(nfc_reg)};
                    end
                    nfc_next = nfc_reg + 1'b1;
                    state_next = S_EOS;
                end
                else if (bytes_in_reg >= next_check_reg && stream_block_reg)
                begin
                    next_check_next = sat_add(bytes_in_reg, 32'(interval_reg));
                    if (divisor == '0)
                    begin
                        div_q_next = lzwc_pkg::RATIO_INF;
                        state_next = S_RCMP;
                    end
                    else
                    begin
                        div_q_next = dividend;
                        div_r_next = '0;
                        div_d_next = divisor;
                        div_cnt_next = '0;
                        state_next = S_DIV;
                    end
                end
                else
                begin
                    state_next = S_EOS;
                end
            end
            S_DIV:
            begin
                if (div_rs >= {1'b0, div_d_reg})
                begin
                    div_r_next = div_rs - {1'b0, div_d_reg};
                    div_q_next = {div_q_reg[30:0], 1'b1};
                end
                else
                begin
                    div_r_next = div_rs;
                    div_q_next = {div_q_reg[30:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_cnt_reg == 5'd31)
                begin
                    state_next = S_RCMP;
                end
            end
            S_RCMP:
            begin
                if (div_q_reg > best_reg)
                begin
                    best_next = div_q_reg;
                    state_next = S_EOS;
                end
                else
                begin
                    best_next = '0;
                    clr_start = 1'b1;
                    nfc_next = lzwc_pkg::NFC_W'(lzwc_pkg::FIRST_CODE);
                    cp_next = 1'b1;
                    emit_go = 1'b1;
                    emit_code = lzwc_pkg::NFC_W'(lzwc_pkg::CLEAR_CODE);
                    emit_ret = R_RATIO;
                end
            end
            S_EOS:
            begin
                if (eos_reg)
                begin
                    emit_go = 1'b1;
                    emit_code = lzwc_pkg::NFC_W'(prefix_reg);
                    emit_ret = R_EOS;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_TAIL:
            begin
                started_next = 1'b0;
                bo_next = '0;
                if (bo_reg != '0)
                begin
                    flush_go = 1'b1;
                    flush_len = PIDX_BITS'((lzwc_pkg::BO_W + 1)'(bo_reg) + 7'd7 >> 3);
                    flush_ret = F_DONE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next = '{out_byte: hold_byte_reg, last_of_run: 1'b1,
                                      stream_done: eos_reg};
                    hold_valid_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // code packing entry
        if (emit_go)
        begin
            ev_next = 16'(emit_code) & ((16'd1 << cw_reg) - 16'd1);
            erem_next = 5'(cw_reg);
            pidx_next = PIDX_BITS'(bo_reg >> 3);
            eoff_next = bo_reg[2:0];
            efirst_next = 1'b1;
            ret_next = emit_ret;
            state_next = S_PACK;
        end

        // byte flush entry
        if (flush_go)
        begin
            fcnt_next = '0;
            flen_next = flush_len;
            fret_next = flush_ret;
            emitted_next = sat_add(emitted_reg, 32'(flush_len));
            state_next = S_FLUSH;
        end

        // one byte held back so the last of a run can be marked
        if (put_en)
        begin
            if (hold_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_data_next = '{out_byte: hold_byte_reg, last_of_run: 1'b0,
                                  stream_done: 1'b0};
            end
            hold_valid_next = 1'b1;
            hold_byte_next = put_byte;
        end

        // table clearing sweep
        if (clr_start)
        begin
            clr_busy_next = 1'b1;
            clr_addr_next = '0;
        end
        else if (clr_busy_reg)
        begin
            mem_we = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == HSIZE - 1'b1)
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg <= R_EOS;
            fret_reg <= F_DONE;
            c_reg <= '0;
            eos_reg <= 1'b0;
            max_bits_reg <= 4'(lzwc_pkg::CODE_BITS_MAX);
            block_mode_reg <= 1'b1;
            interval_reg <= lzwc_pkg::CFG_DATA_W'(lzwc_pkg::CHECK_RESET);
            stream_bits_reg <= 4'(lzwc_pkg::CODE_BITS_MAX);
            stream_block_reg <= 1'b1;
            top_code_reg <= lzwc_pkg::NFC_W'(1) << lzwc_pkg::CODE_BITS_MAX;
            for (int i = 0; i < lzwc_pkg::PACK_DEPTH; i++)
            begin
                pack_reg[i] <= '0;
            end
            bo_reg <= '0;
            cw_reg <= lzwc_pkg::CW_W'(lzwc_pkg::START_BITS);
            wlc_reg <= (lzwc_pkg::NFC_W'(1) << lzwc_pkg::START_BITS) - 1'b1;
            nfc_reg <= lzwc_pkg::NFC_W'(lzwc_pkg::FIRST_CODE);
            prefix_reg <= '0;
            started_reg <= 1'b0;
            cp_reg <= 1'b0;
            bytes_in_reg <= 32'd1;
            emitted_reg <= 32'd3;
            best_reg <= '0;
            next_check_reg <= lzwc_pkg::CHECK_RESET;
            slot_reg <= '0;
            disp_reg <= '0;
            tries_reg <= '0;
            empty_reg <= 1'b0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            ev_reg <= '0;
            erem_reg <= '0;
            pidx_reg <= '0;
            eoff_reg <= '0;
            efirst_reg <= 1'b0;
            fcnt_reg <= '0;
            flen_reg <= '0;
            hdr_cnt_reg <= '0;
            div_q_reg <= '0;
            div_r_reg <= '0;
            div_d_reg <= '0;
            div_cnt_reg <= '0;
            hold_valid_reg <= 1'b0;
            hold_byte_reg <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            fret_reg <= fret_next;
            c_reg <= c_next;
            eos_reg <= eos_next;
            max_bits_reg <= max_bits_next;
            block_mode_reg <= block_mode_next;
            interval_reg <= interval_next;
            stream_bits_reg <= stream_bits_next;
            stream_block_reg <= stream_block_next;
            top_code_reg <= top_code_next;
            pack_reg <= pack_next;
            bo_reg <= bo_next;
            cw_reg <= cw_next;
            wlc_reg <= wlc_next;
            nfc_reg <= nfc_next;
            prefix_reg <= prefix_next;
            started_reg <= started_next;
            cp_reg <= cp_next;
            bytes_in_reg <= bytes_in_next;
            emitted_reg <= emitted_next;
            best_reg <= best_next;
            next_check_reg <= next_check_next;
            slot_reg <= slot_next;
            disp_reg <= disp_next;
            tries_reg <= tries_next;
            empty_reg <= empty_next;
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
            ev_reg <= ev_next;
            erem_reg <= erem_next;
            pidx_reg <= pidx_next;
            eoff_reg <= eoff_next;
            efirst_reg <= efirst_next;
            fcnt_reg <= fcnt_next;
            flen_reg <= flen_next;
            hdr_cnt_reg <= hdr_cnt_next;
            div_q_reg <= div_q_next;
            div_r_reg <= div_r_next;
            div_d_reg <= div_d_next;
            div_cnt_reg <= div_cnt_next;
            hold_valid_reg <= hold_valid_next;
            hold_byte_reg <= hold_byte_next;
            out_valid_reg <= out_valid_next;
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTHESIS
    // a new byte never pushes out a held byte into a busy output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (put_en && hold_valid_reg) |-> (!out_valid_reg || out_ready))
        else $error("output register overrun");

    // table entries are never written while the clearing sweep runs
    assert property (@(posedge clk) disable iff (!rst_n)
        miss_wr |-> !clr_busy_reg)
        else $error("table write during clearing sweep");

    // code width stays between the start width and one past the largest
    assert property (@(posedge clk) disable iff (!rst_n)
        (cw_reg >= lzwc_pkg::CW_W'(lzwc_pkg::START_BITS))
        && (cw_reg <= lzwc_pkg::CW_W'(lzwc_pkg::CODE_BITS_MAX + 1)))
        else $error("code width out of range");

    // between bytes the pack buffer never holds a full group of codes
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (bo_reg < lzwc_pkg::BO_W'({cw_reg, 3'b000})))
        else $error("bit offset past pack buffer");

    // an input transfer always finds the previous run fully handed over
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !hold_valid_reg)
        else $error("held byte left from previous run");
`endif

endmodule
